/* design/rfc_pkg.sv */
// Shared types and constants for the rail fence cipher block.
package rfc_pkg;

  // Fixed field widths
  localparam int BYTE_W       = 8;
  localparam int RAIL_TOTAL_W = 5;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_IDX_W    = 1;

  // Default sizing
  localparam int RFC_MAX_LEN   = 64;
  localparam int RFC_MAX_RAILS = 16;

  // Register reset values
  localparam logic [RAIL_TOTAL_W-1:0] RAIL_TOTAL_RST = RAIL_TOTAL_W'(2);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAIL_TOTAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 1'b1;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Commands to the per-rail counter bank
  typedef struct packed {
    logic clr;   // zero every count and the running sum
    logic inc;   // count[idx] += 1
    logic pfx;   // count[idx] <= sum; sum += old count[idx]
  } cnt_cmd_t;

  // Control sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_PREFIX,
    S_SCAT,
    S_RD,
    S_RD1,
    S_OUT
  } rfc_state_t;

endpackage

/* design/rfc_ram.sv */
// Generic simple dual-port RAM with registered read.
module rfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/rfc_zigzag.sv */
// Zigzag rail walker: tags each loaded position with its rail.
module rfc_zigzag #(
  parameter int MAX_RAILS = rfc_pkg::RFC_MAX_RAILS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [rfc_pkg::RAIL_TOTAL_W-1:0] rail_total_i,
  input  logic                             step_i,
  input  logic                             clear_i,
  output logic [$clog2(MAX_RAILS)-1:0]     tag_o
);

  localparam int TW = $clog2(MAX_RAILS);
  localparam int RW = $clog2(MAX_RAILS + 1);
  localparam int CW = (RW > rfc_pkg::RAIL_TOTAL_W) ? RW : rfc_pkg::RAIL_TOTAL_W;

  logic [TW-1:0] row_r, row_nxt;
  logic          down_r, down_nxt;
  logic [CW-1:0] rt_ext, r_eff, r_m1, tag_ext, inc_ext, dec_ext;

  // Effective rail count: zero reads as one, large values saturate
  always_comb begin
    rt_ext = CW'(rail_total_i);
    if (rt_ext == '0) begin
      r_eff = CW'(1);
    end else if (rt_ext > CW'(MAX_RAILS)) begin
      r_eff = CW'(MAX_RAILS);
    end else begin
      r_eff = rt_ext;
    end
    r_m1 = r_eff - CW'(1);
  end

  // Current row, clamped to the last rail
  always_comb begin
    tag_ext = (CW'(row_r) > r_m1) ? r_m1 : CW'(row_r);
    inc_ext = tag_ext + CW'(1);
    dec_ext = tag_ext - CW'(1);
  end

  assign tag_o = TW'(tag_ext);

  // Walk update
  always_comb begin
    row_nxt  = row_r;
    down_nxt = down_r;
    if (clear_i) begin
      row_nxt  = '0;
      down_nxt = 1'b1;
    end else if (step_i) begin
      if (r_eff <= CW'(1)) begin
        row_nxt  = '0;
        down_nxt = 1'b1;
      end else if (down_r) begin
        row_nxt  = TW'(inc_ext);
        down_nxt = (inc_ext < r_m1);
      end else begin
        row_nxt  = TW'(dec_ext);
        down_nxt = (dec_ext == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      down_r <= 1'b1;
    end else begin
      row_r  <= row_nxt;
      down_r <= down_nxt;
    end
  end

  // The tag handed out always lies on an existing rail
  a_tag_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_i |-> (CW'(tag_o) <= r_m1))
    else $error("zigzag tag beyond last rail");

endmodule

/* design/rfc_rail_cnt.sv */
// Per-rail byte counts, turned in place into rail start offsets.
module rfc_rail_cnt #(
  parameter int MAX_LEN   = rfc_pkg::RFC_MAX_LEN,
  parameter int MAX_RAILS = rfc_pkg::RFC_MAX_RAILS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rfc_pkg::cnt_cmd_t               cmd_i,
  input  logic [$clog2(MAX_RAILS)-1:0]    idx_i,
  output logic [$clog2(MAX_LEN + 1)-1:0]  cnt_o
);

  localparam int CNTW = $clog2(MAX_LEN + 1);

  logic [CNTW-1:0] cnt_r   [MAX_RAILS];
  logic [CNTW-1:0] cnt_nxt [MAX_RAILS];
  logic [CNTW-1:0] sum_r, sum_nxt;

  assign cnt_o = cnt_r[idx_i];

  // One entry touched per cycle; clear wipes the whole bank
  always_comb begin
    cnt_nxt = cnt_r;
    sum_nxt = sum_r;
    if (cmd_i.clr) begin
      for (int i = 0; i < MAX_RAILS; i++) begin
        cnt_nxt[i] = '0;
      end
      sum_nxt = '0;
    end else if (cmd_i.inc) begin
      cnt_nxt[idx_i] = cnt_r[idx_i] + CNTW'(1);
    end else if (cmd_i.pfx) begin
      cnt_nxt[idx_i] = sum_r;
      sum_nxt        = sum_r + cnt_r[idx_i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_RAILS; i++) begin
        cnt_r[i] <= '0;
      end
      sum_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

/* design/rail_fence_cipher_top.sv */
// Top level of the rail fence cipher: load, offset, scatter and emit control.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   input   | in_valid/in_ready, in_byte, in_last     | in
//   result  | out_valid/out_ready, out_byte, out_last,| out
//           | out_truncated                           |
//   config  | cfg_we, cfg_index, cfg_wdata            | in
//
// Loading writes each byte that fits, with its rail tag, into the message RAM.
// After the last byte, the offset pass turns rail counts into start offsets
// one rail at a time, the scatter pass moves through the message RAM into the
// order RAM, then each result takes three steps in either direction (order RAM
// read, a decode's second read at the source position, output register load).
// Reset is synchronous; no clearing pass, the RAMs need none.
// A stalled result holds the emit sequence; the next message may load while
// the final result still waits in the output register.
module rail_fence_cipher_top #(
  parameter int MAX_LEN   = rfc_pkg::RFC_MAX_LEN,
  parameter int MAX_RAILS = rfc_pkg::RFC_MAX_RAILS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [rfc_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            in_last,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [rfc_pkg::BYTE_W-1:0]      out_byte,
  output logic                            out_last,
  output logic                            out_truncated,
  // configuration
  input  logic                            cfg_we,
  input  logic [rfc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rfc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW   = $clog2(MAX_LEN);
  localparam int TW   = $clog2(MAX_RAILS);
  localparam int CNTW = $clog2(MAX_LEN + 1);
  localparam int BW   = rfc_pkg::BYTE_W;
  localparam int MW   = BW + TW;
  localparam int OBW  = (CNTW > BW) ? CNTW : BW;

  // Configuration registers
  logic [rfc_pkg::RAIL_TOTAL_W-1:0] rail_total_r, rail_total_nxt;
  logic                             direction_r, direction_nxt;

  always_comb begin
    rail_total_nxt = rail_total_r;
    direction_nxt  = direction_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rfc_pkg::CFG_RAIL_TOTAL: rail_total_nxt = cfg_wdata[rfc_pkg::RAIL_TOTAL_W-1:0];
        rfc_pkg::CFG_DIRECTION:  direction_nxt  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rail_total_r <= rfc_pkg::RAIL_TOTAL_RST;
      direction_r  <= rfc_pkg::DIR_ENCODE;
    end else begin
      rail_total_r <= rail_total_nxt;
      direction_r  <= direction_nxt;
    end
  end

  // Sequencer and message state
  rfc_pkg::rfc_state_t state_r, state_nxt;
  logic [CNTW-1:0] len_r, len_nxt;
  logic            ovf_r, ovf_nxt;
  logic            dir_r, dir_nxt;
  logic [TW-1:0]   pfx_r, pfx_nxt;
  logic [CNTW-1:0] si_r, si_nxt;
  logic            sv_r, sv_nxt;
  logic [AW-1:0]   sidx_r, sidx_nxt;
  logic [CNTW-1:0] k_r, k_nxt;

  // Output register
  logic          ov_r, ov_nxt;
  logic [BW-1:0] ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic          ot_r, ot_nxt;

  // Datapath wiring
  logic              in_xfer, has_room, out_free, out_load, last_item, scat_rd;
  logic              zz_step, zz_clear;
  logic [TW-1:0]     zz_tag;
  rfc_pkg::cnt_cmd_t cnt_cmd;
  logic [TW-1:0]     cnt_idx;
  logic [CNTW-1:0]   cnt_rd;
  logic              msg_we, msg_re;
  logic [AW-1:0]     msg_waddr, msg_raddr;
  logic [MW-1:0]     msg_wdata, msg_rdata;
  logic              obf_we, obf_re;
  logic [AW-1:0]     obf_waddr, obf_raddr;
  logic [OBW-1:0]    obf_wdata, obf_rdata;
  logic [TW-1:0]     msg_tag;
  logic [BW-1:0]     msg_byte, sel_byte;

  assign in_ready  = (state_r == rfc_pkg::S_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign has_room  = (len_r < CNTW'(MAX_LEN));
  assign out_free  = !ov_r || out_ready;
  assign last_item = ((k_r + CNTW'(1)) == len_r);
  assign scat_rd   = (si_r < len_r);
  assign msg_tag   = msg_rdata[MW-1:BW];
  assign msg_byte  = msg_rdata[BW-1:0];
  assign sel_byte  = (dir_r == rfc_pkg::DIR_DECODE) ? msg_byte : obf_rdata[BW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfc_pkg::S_LOAD:   if (in_xfer && in_last) state_nxt = rfc_pkg::S_PREFIX;
      rfc_pkg::S_PREFIX: if (pfx_r == TW'(MAX_RAILS - 1)) state_nxt = rfc_pkg::S_SCAT;
      rfc_pkg::S_SCAT:   if (!scat_rd && !sv_r) state_nxt = rfc_pkg::S_RD;
      rfc_pkg::S_RD:     state_nxt = rfc_pkg::S_RD1;
      rfc_pkg::S_RD1:    state_nxt = rfc_pkg::S_OUT;
      rfc_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = last_item ? rfc_pkg::S_LOAD : rfc_pkg::S_RD;
        end
      end
      default:           state_nxt = rfc_pkg::S_LOAD;
    endcase
  end

  // Outputs and datapath controls
  always_comb begin
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    dir_nxt   = dir_r;
    pfx_nxt   = '0;
    si_nxt    = '0;
    sv_nxt    = 1'b0;
    sidx_nxt  = sidx_r;
    k_nxt     = '0;
    zz_step   = 1'b0;
    zz_clear  = 1'b0;
    cnt_cmd   = '0;
    cnt_idx   = zz_tag;
    msg_we    = 1'b0;
    msg_waddr = len_r[AW-1:0];
    msg_wdata = {zz_tag, in_byte};
    msg_re    = 1'b0;
    msg_raddr = si_r[AW-1:0];
    obf_we    = 1'b0;
    obf_waddr = sidx_r;
    obf_wdata = OBW'(msg_byte);
    obf_re    = 1'b0;
    obf_raddr = k_r[AW-1:0];
    out_load  = 1'b0;
    unique case (state_r)
      // store one byte and its rail per transfer; flag overflow when full
      rfc_pkg::S_LOAD: begin
        if (in_xfer) begin
          if (has_room) begin
            msg_we      = 1'b1;
            zz_step     = 1'b1;
            cnt_cmd.inc = 1'b1;
            len_nxt     = len_r + CNTW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            dir_nxt = direction_r;
          end
        end
      end
      // running sum over the rails, one rail a cycle
      rfc_pkg::S_PREFIX: begin
        cnt_idx     = pfx_r;
        cnt_cmd.pfx = 1'b1;
        pfx_nxt     = pfx_r + TW'(1);
      end
      // read position i; encode: byte to rail offset, decode: offset at i
      rfc_pkg::S_SCAT: begin
        msg_re   = scat_rd;
        sv_nxt   = scat_rd;
        sidx_nxt = si_r[AW-1:0];
        si_nxt   = scat_rd ? (si_r + CNTW'(1)) : si_r;
        if (sv_r) begin
          cnt_idx     = msg_tag;
          cnt_cmd.inc = 1'b1;
          obf_we      = 1'b1;
          if (dir_r == rfc_pkg::DIR_DECODE) begin
            obf_waddr = sidx_r;
            obf_wdata = OBW'(cnt_rd);
          end else begin
            obf_waddr = cnt_rd[AW-1:0];
            obf_wdata = OBW'(msg_byte);
          end
        end
      end
      rfc_pkg::S_RD: begin
        obf_re = 1'b1;
        k_nxt  = k_r;
      end
      // decode needs a second read at the source position
      rfc_pkg::S_RD1: begin
        msg_re    = (dir_r == rfc_pkg::DIR_DECODE);
        msg_raddr = obf_rdata[AW-1:0];
        k_nxt     = k_r;
      end
      rfc_pkg::S_OUT: begin
        k_nxt = k_r;
        if (out_free) begin
          out_load = 1'b1;
          k_nxt    = k_r + CNTW'(1);
          if (last_item) begin
            cnt_cmd.clr = 1'b1;
            zz_clear    = 1'b1;
            len_nxt     = '0;
            ovf_nxt     = 1'b0;
            k_nxt       = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    ot_nxt = ot_r;
    if (out_load) begin
      ov_nxt = 1'b1;
      ob_nxt = sel_byte;
      ol_nxt = last_item;
      ot_nxt = ovf_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfc_pkg::S_LOAD;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      dir_r   <= rfc_pkg::DIR_ENCODE;
      pfx_r   <= '0;
      si_r    <= '0;
      sv_r    <= 1'b0;
      k_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      dir_r   <= dir_nxt;
      pfx_r   <= pfx_nxt;
      si_r    <= si_nxt;
      sv_r    <= sv_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sidx_r <= sidx_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
    ot_r   <= ot_nxt;
  end

  assign out_valid     = ov_r;
  assign out_byte      = ob_r;
  assign out_last      = ol_r;
  assign out_truncated = ot_r;

  // Rail walker
  rfc_zigzag #(
    .MAX_RAILS (MAX_RAILS)
  ) u_zigzag (
    .clk          (clk),
    .rst_n        (rst_n),
    .rail_total_i (rail_total_r),
    .step_i       (zz_step),
    .clear_i      (zz_clear),
    .tag_o        (zz_tag)
  );

  // Per-rail counts and start offsets
  rfc_rail_cnt #(
    .MAX_LEN   (MAX_LEN),
    .MAX_RAILS (MAX_RAILS)
  ) u_rail_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd_i (cnt_cmd),
    .idx_i (cnt_idx),
    .cnt_o (cnt_rd)
  );

  // Message RAM: {rail tag, byte} by position
  rfc_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_LEN)
  ) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (msg_wdata),
    .re    (msg_re),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

  // Order RAM: encoded bytes, or decode source positions
  rfc_ram #(
    .WIDTH (OBW),
    .DEPTH (MAX_LEN)
  ) u_obf_ram (
    .clk   (clk),
    .we    (obf_we),
    .waddr (obf_waddr),
    .wdata (obf_wdata),
    .re    (obf_re),
    .raddr (obf_raddr),
    .rdata (obf_rdata)
  );

  // Length never runs past the buffer
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNTW'(MAX_LEN))
    else $error("loaded length beyond buffer depth");

  // A last-marked transfer starts the offset pass
  a_last_to_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last) |=> (state_r == rfc_pkg::S_PREFIX))
    else $error("last transfer did not start offset pass");

  // Emit index stays inside the loaded message
  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfc_pkg::S_OUT) |-> (k_r < len_r))
    else $error("emit index beyond message length");

  // Scatter writes only land below the loaded length
  a_scat_addr: assert property (@(posedge clk) disable iff (!rst_n)
    obf_we |-> (CNTW'(obf_waddr) < len_r))
    else $error("scatter address beyond message length");

endmodule

/* test/rail_fence_cipher_top_test.sv */
// Self-checking testbench for the rail fence cipher top: random handshakes, predicted permutations.
`timescale 1ns / 1ps

module rail_fence_cipher_top_test;

  localparam int MSG_DEPTH   = rfc_pkg::RFC_MAX_LEN;
  localparam int RAIL_LIMIT  = rfc_pkg::RFC_MAX_RAILS;
  localparam int RANDOM_CHARS = 300;
  localparam int SETTLE      = 40;       // covers offset pass plus scatter on a short tail
  localparam int HOLD_OFF    = 400;
  localparam int CYCLE_LIMIT = 200000;

  // One character of a permuted message as it should leave the block
  typedef struct packed {
    logic [rfc_pkg::BYTE_W-1:0] ch;
    logic                       last;
    logic                       cut;
  } cipher_char_t;

  // Tracks the message being loaded and predicts the permuted output
  class rail_fence_board;
    logic [rfc_pkg::RAIL_TOTAL_W-1:0] rail_setting;
    logic                             decode_mode;
    logic [rfc_pkg::BYTE_W-1:0]       msg_mem [MSG_DEPTH];
    int unsigned             rail_of [MSG_DEPTH];
    int unsigned             rail_cnt [RAIL_LIMIT];
    int unsigned             msg_len;
    int unsigned             row;
    bit                      heading_down;
    bit                      overflowed;
    cipher_char_t            expected_chars[$];
    int                      errors;
    int                      messages;
    int                      chars_checked;
    int                      cut_messages;

    function new();
      rail_setting = rfc_pkg::RAIL_TOTAL_RST;
      decode_mode  = rfc_pkg::DIR_ENCODE;
      errors = 0;
      messages = 0;
      chars_checked = 0;
      cut_messages = 0;
      restart_message();
    endfunction

    function void restart_message();
      foreach (rail_cnt[i]) rail_cnt[i] = 0;
      msg_len = 0;
      row = 0;
      heading_down = 1'b1;
      overflowed = 1'b0;
    endfunction

    function void set_reg(logic [rfc_pkg::CFG_IDX_W-1:0] idx,
                          logic [rfc_pkg::CFG_DATA_W-1:0] val);
      if (idx == rfc_pkg::CFG_RAIL_TOTAL) rail_setting = val;
      else decode_mode = val[0];
    endfunction

    // Load one character; on the last mark, queue the whole permuted message
    function void note_byte(logic [rfc_pkg::BYTE_W-1:0] ch, logic fin);
      int unsigned  rails;
      int unsigned  tag;
      int unsigned  k;
      int unsigned  sum;
      int unsigned  t;
      int unsigned  start [RAIL_LIMIT];
      logic [rfc_pkg::BYTE_W-1:0] perm [MSG_DEPTH];
      cipher_char_t e;

      rails = rail_setting;
      if (rails == 0) rails = 1;
      if (rails > RAIL_LIMIT) rails = RAIL_LIMIT;

      if (msg_len < MSG_DEPTH) begin
        // zigzag walk, clamped if the rail count shrank mid-message
        if (row > rails - 1) row = rails - 1;
        tag = row;
        if (rails <= 1) begin
          row = 0;
          heading_down = 1'b1;
        end else if (heading_down) begin
          row++;
          if (row >= rails - 1) heading_down = 1'b0;
        end else begin
          row--;
          if (row == 0) heading_down = 1'b1;
        end
        msg_mem[msg_len] = ch;
        rail_of[msg_len] = tag;
        rail_cnt[tag]++;
        msg_len++;
      end else begin
        overflowed = 1'b1;
      end

      if (!fin) return;

      if (decode_mode == rfc_pkg::DIR_ENCODE) begin
        // rail by rail, each in order of position
        k = 0;
        for (int r = 0; r < RAIL_LIMIT; r++)
          for (int i = 0; i < msg_len; i++)
            if (rail_of[i] == r) begin
              perm[k] = msg_mem[i];
              k++;
            end
      end else begin
        // rail segments placed by prefix sums, read back in zigzag order
        sum = 0;
        for (int r = 0; r < RAIL_LIMIT; r++) begin
          start[r] = sum;
          sum += rail_cnt[r];
        end
        for (int i = 0; i < msg_len; i++) begin
          t = rail_of[i] % RAIL_LIMIT;
          perm[i] = msg_mem[start[t] % MSG_DEPTH];
          start[t]++;
        end
      end

      for (int i = 0; i < msg_len; i++) begin
        e.ch   = perm[i];
        e.last = (i + 1 == msg_len);
        e.cut  = overflowed;
        expected_chars.push_back(e);
      end
      messages++;
      if (overflowed) cut_messages++;
      restart_message();
    endfunction

    function void check_result(logic [rfc_pkg::BYTE_W-1:0] ch, logic fin, logic cut);
      cipher_char_t e;
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_byte=%0h out_last=%0b out_truncated=%0b", ch, fin, cut);
        errors++;
        return;
      end
      e = expected_chars.pop_front();
      chars_checked++;
      if (ch !== e.ch) begin
        $error("out_byte: expected %0h, got %0h", e.ch, ch);
        errors++;
      end
      if (fin !== e.last) begin
        $error("out_last: expected %0b, got %0b", e.last, fin);
        errors++;
      end
      if (cut !== e.cut) begin
        $error("out_truncated: expected %0b, got %0b", e.cut, cut);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [rfc_pkg::BYTE_W-1:0] in_byte = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rfc_pkg::BYTE_W-1:0] out_byte;
  logic out_last;
  logic out_truncated;
  logic cfg_we = 1'b0;
  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rfc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  rail_fence_board board;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  int chars_sent = 0;
  int cycles = 0;
  logic [rfc_pkg::BYTE_W-1:0] text[$];

  rail_fence_cipher_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_last(out_last), .out_truncated(out_truncated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial forever #1 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rail_fence_cipher_top_test: FAIL");
      $finish;
    end
  end

  // Result side: check each transfer, then pick next ready
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        board.check_result(out_byte, out_last, out_truncated);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (recv_idle != 0 && $urandom_range(99) < recv_idle) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // One input transfer, with random idle cycles ahead of it
  task automatic send_char(input logic [rfc_pkg::BYTE_W-1:0] ch, input logic fin);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= ch;
    in_last  <= fin;
    do @(posedge clk); while (!in_ready);
    board.note_byte(ch, fin);
    chars_sent++;
  endtask

  // Send the buffered text, marking the final character only when closing
  task automatic send_text(input bit close);
    for (int i = 0; i < text.size(); i++)
      send_char(text[i], close && (i == text.size() - 1));
    text.delete();
  endtask

  task automatic fill_text(input int len);
    for (int i = 0; i < len; i++)
      text.push_back(rfc_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every predicted character has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rfc_pkg::CFG_IDX_W-1:0] idx,
                           input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[rfc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val[rfc_pkg::CFG_DATA_W-1:0]);
    @(posedge clk);
  endtask

  initial begin
    int seg;
    int random_start;
    int len;
    int rails;
    int extremes [4];

    board = new();
    extremes = '{0, 1, 16, 31};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings with extreme bytes, zero byte included
    text.push_back(8'h00);
    text.push_back(8'hFF);
    text.push_back(8'h55);
    text.push_back(8'hAA);
    text.push_back(8'h01);
    send_text(1);
    wait_idle();

    // single rail passes the text through
    write_reg(rfc_pkg::CFG_RAIL_TOTAL, 1);
    fill_text(3);
    send_text(1);
    wait_idle();

    // zero rails behave as one, decoding
    write_reg(rfc_pkg::CFG_RAIL_TOTAL, 0);
    write_reg(rfc_pkg::CFG_DIRECTION, rfc_pkg::DIR_DECODE);
    fill_text(3);
    send_text(1);
    wait_idle();

    // rail count above the limit saturates
    write_reg(rfc_pkg::CFG_RAIL_TOTAL, 31);
    write_reg(rfc_pkg::CFG_DIRECTION, rfc_pkg::DIR_ENCODE);
    fill_text(6);
    send_text(1);
    wait_idle();

    // rail count shrinks halfway through a message
    write_reg(rfc_pkg::CFG_RAIL_TOTAL, 3);
    write_reg(rfc_pkg::CFG_DIRECTION, rfc_pkg::DIR_DECODE);
    fill_text(4);
    send_text(0);
    wait_idle();
    write_reg(rfc_pkg::CFG_RAIL_TOTAL, 2);
    fill_text(3);
    send_text(1);
    wait_idle();

    // Random segments: new settings each time, three idling regimes
    random_start = chars_sent;
    seg = 0;
    while (chars_sent - random_start < RANDOM_CHARS) begin
      if (chars_sent - random_start < RANDOM_CHARS / 3) begin
        send_idle = 11;
        recv_idle = 49;
      end else if (chars_sent - random_start < 2 * RANDOM_CHARS / 3) begin
        send_idle = 49;
        recv_idle = 11;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (seg % 3 == 0) rails = extremes[$urandom_range(0, 3)];
      else rails = $urandom_range(0, 31);
      write_reg(rfc_pkg::CFG_RAIL_TOTAL, rails);
      write_reg(rfc_pkg::CFG_DIRECTION,
                ($urandom_range(0, 15) << 1) | $urandom_range(0, 1));
      for (int m = 0; m < 4; m++) begin
        if (m == 0 && seg == 1) len = 70;                 // overflow, last byte dropped
        else if (m == 0 && seg == 2) len = MSG_DEPTH;     // exactly full
        else if (m == 0 && seg == 3) len = MSG_DEPTH + 1;
        else if ($urandom_range(0, 11) == 0) len = $urandom_range(60, 70);
        else len = $urandom_range(1, 12);
        fill_text(len);
        send_text(1);
      end
      wait_idle();
      seg++;
    end

    // Long receiver hold-off while the sender keeps pushing messages
    send_idle = 0;
    recv_idle = 0;
    write_reg(rfc_pkg::CFG_RAIL_TOTAL, $urandom_range(2, 16));
    write_reg(rfc_pkg::CFG_DIRECTION, $urandom_range(0, 1));
    hold_left = HOLD_OFF;
    for (int m = 0; m < 3; m++) begin
      fill_text(12);
      send_text(1);
    end
    wait_idle();
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d characters in %0d messages (%0d cut at depth), %0d results checked,",
             chars_sent, board.messages, board.cut_messages, board.chars_checked);
    $display("encode and decode over rail counts 0 to 31, with and without handshake gaps.");
    if (board.errors == 0 && board.expected_chars.size() == 0) begin
      $display("rail_fence_cipher_top_test: PASS");
    end else begin
      $display("rail_fence_cipher_top_test: FAIL");
    end
    $finish;
  end

endmodule
